// File: rtl/core/nec_ir_transmitter_top_macros.svh
// Assertion macros shared by the NEC infrared transmitter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef NEC_IR_TRANSMITTER_TOP_MACROS_SVH
`define NEC_IR_TRANSMITTER_TOP_MACROS_SVH

// Same-cycle implication: whenever the antecedent holds, the consequent holds too.
`define NECIRTX_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: the consequent holds in the cycle after the antecedent.
`define NECIRTX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/necirtx_pkg.sv
// Shared types and timing constants of the NEC infrared transmitter.
// No dependencies; used by necirtx_engine and nec_ir_transmitter_top.
package necirtx_pkg;

   // Upper limit on the number of repeat codes in one frame.
   localparam int MAX_REPEATS = 255;

   localparam int WAIT_W  = 17;
   localparam int BURST_W = 9;
   localparam int CPH_W   = 5;

   // Request function codes.
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_SEND = 1'b1;

   // Addresses above this value are sent as extended NEC.
   localparam logic [15:0] EXT_ADDR_LIMIT = 16'h00FF;

   // Piece lengths in microseconds.
   localparam logic [WAIT_W-1:0] LONG_MARK_US     = WAIT_W'(9000);
   localparam logic [WAIT_W-1:0] SHORT_MARK_US    = WAIT_W'(560);
   localparam logic [WAIT_W-1:0] LEADER_SPACE_US  = WAIT_W'(4500);
   localparam logic [WAIT_W-1:0] REPEAT_SPACE_US  = WAIT_W'(2250);
   localparam logic [WAIT_W-1:0] ZERO_SPACE_US    = WAIT_W'(560);
   localparam logic [WAIT_W-1:0] ONE_SPACE_US     = WAIT_W'(1690);
   localparam logic [WAIT_W-1:0] ONE_SPACE_CAR_US = WAIT_W'(1680);
   localparam logic [WAIT_W-1:0] REPEAT_GAP_US    = WAIT_W'(110000);
   localparam logic [WAIT_W-1:0] PULSE_HIGH_US    = WAIT_W'(7);

   // Carrier burst shapes.
   localparam logic [BURST_W-1:0] LONG_PULSES   = BURST_W'(375);
   localparam logic [BURST_W-1:0] SHORT_PULSES  = BURST_W'(23);
   localparam logic [CPH_W-1:0]   LONG_LOW_US   = CPH_W'(18);
   localparam logic [CPH_W-1:0]   SHORT_LOW_US  = CPH_W'(17);

   typedef struct packed {
      logic        func;
      logic [15:0] address;
      logic [7:0]  command;
      logic [7:0]  repeat_count;
   } req_type;

   typedef struct packed {
      logic pin_level;
      logic busy_res;
      logic done_res;
   } rsp_type;

endpackage

// File: rtl/core/nec_ir_transmitter_top.sv
// Top level of the NEC infrared transmitter: handshakes, control register, sequencer.
// Depends on necirtx_pkg, necirtx_engine and nec_ir_transmitter_top_macros.svh.

// The block takes one request per clock cycle: either a one-microsecond tick
// (func = 0) or a send request (func = 1) carrying an address, a command and a
// repeat count. Each accepted request yields exactly one registered result, shown in the
// cycle after acceptance, giving the pin level, whether a frame is running and
// whether this tick finished the stop mark. A single result register separates
// the two sides; while it holds an untaken result and the result side stalls,
// the request side stalls too, otherwise a request is taken every cycle. The
// sequencer state is updated once per request, so the rate is bounded only by
// the result side. Send requests arriving during a frame are dropped but still
// produce a result. The carrier_enable register (reset 1) is written through the
// csr port, which is always ready; it should be changed only while idle.
`include "nec_ir_transmitter_top_macros.svh"

module nec_ir_transmitter_top (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_command,
   input  logic [7:0]  req_repeat_count,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_pin_level,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   // Control register write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 carrier_ff, carrier_in;
   logic                 req_accept;
   necirtx_pkg::req_type req;
   necirtx_pkg::rsp_type rsp;

   // A request is taken whenever the result register is free or being emptied.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign req.func         = req_func;
   assign req.address      = req_address;
   assign req.command      = req_command;
   assign req.repeat_count = req_repeat_count;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end
      carrier_in = carrier_ff;
      if (csr_valid && csr_ready) begin
         carrier_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         carrier_ff   <= 1'b1;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         carrier_ff   <= carrier_in;
      end
   end

   // The sequencer also holds the result register, loaded on every accepted request.
   necirtx_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .step_en        (req_accept),
      .carrier_enable (carrier_ff),
      .req            (req),
      .rsp            (rsp)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pin_level = rsp.pin_level;
   assign rsp_busy_res  = rsp.busy_res;
   assign rsp_done_res  = rsp.done_res;

   `NECIRTX_ASSERT_NEXT(a_accept_gives_result, clock, reset, req_accept, rsp_valid_ff, "accepted request produced no result")
   `NECIRTX_ASSERT_IMPLIES(a_free_never_stalls, clock, reset, !rsp_valid_ff, !req_stall, "request stalled with an empty result register")
   `NECIRTX_ASSERT_NEXT(a_csr_write_lands, clock, reset, csr_valid && csr_ready, carrier_ff == $past(csr_data), "carrier enable write lost")

endmodule

// File: rtl/core/necirtx_engine.sv
// Frame sequencer of the NEC infrared transmitter: state, timing and result register.
// Depends on necirtx_pkg and nec_ir_transmitter_top_macros.svh.
`include "nec_ir_transmitter_top_macros.svh"

module necirtx_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic                carrier_enable,
   input  necirtx_pkg::req_type req,
   output necirtx_pkg::rsp_type rsp
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEADER,
      PH_BITS,
      PH_REP_HEAD,
      PH_REP_TAIL,
      PH_STOP
   } phase_type;

   typedef struct packed {
      phase_type                        phase;
      logic [4:0]                       bit_index;
      logic [31:0]                      frame_bits;
      logic [7:0]                       repeats_left;
      logic [necirtx_pkg::WAIT_W-1:0]   wait_counter;
      logic [necirtx_pkg::BURST_W-1:0]  burst_counter;
      logic [necirtx_pkg::CPH_W-1:0]    carrier_phase;
      logic                             drive_level;
   } eng_state_type;

   eng_state_type        state_ff, state_in;
   necirtx_pkg::rsp_type rsp_ff, rsp_in;

   function automatic eng_state_type begin_mark(eng_state_type s, logic is_long, logic ce);
      eng_state_type r;
      r = s;
      r.drive_level = 1'b1;
      if (ce) begin
         r.wait_counter  = necirtx_pkg::PULSE_HIGH_US;
         r.burst_counter = is_long ? necirtx_pkg::LONG_PULSES : necirtx_pkg::SHORT_PULSES;
         r.carrier_phase = is_long ? necirtx_pkg::LONG_LOW_US : necirtx_pkg::SHORT_LOW_US;
      end else begin
         r.wait_counter  = is_long ? necirtx_pkg::LONG_MARK_US : necirtx_pkg::SHORT_MARK_US;
         r.burst_counter = necirtx_pkg::BURST_W'(1);
         r.carrier_phase = '0;
      end
      return r;
   endfunction

   function automatic eng_state_type begin_space(eng_state_type s,
                                                 logic [necirtx_pkg::WAIT_W-1:0] len);
      eng_state_type r;
      r = s;
      r.drive_level   = 1'b0;
      r.wait_counter  = len;
      r.burst_counter = '0;
      r.carrier_phase = '0;
      return r;
   endfunction

   // After the data bits or a repeat code: another repeat, or the stop mark.
   function automatic eng_state_type after_data(eng_state_type s, logic ce);
      eng_state_type r;
      r = s;
      if (s.repeats_left != 8'd0) begin
         r.phase = PH_REP_HEAD;
         r = begin_mark(r, 1'b1, ce);
      end else begin
         r.phase = PH_STOP;
         r = begin_mark(r, 1'b0, ce);
      end
      return r;
   endfunction

   always_comb begin
      eng_state_type                   s;
      logic [necirtx_pkg::WAIT_W-1:0]  wc_dec;
      logic [necirtx_pkg::BURST_W-1:0] bc_dec;
      logic [7:0]                      byte0;
      logic [7:0]                      byte1;
      logic                            done;

      s      = state_ff;
      done   = 1'b0;
      wc_dec = (state_ff.wait_counter != '0) ? state_ff.wait_counter - 1'b1 : '0;
      bc_dec = (state_ff.burst_counter != '0) ? state_ff.burst_counter - 1'b1 : '0;
      if (req.address > necirtx_pkg::EXT_ADDR_LIMIT) begin
         byte0 = req.address[7:0];
         byte1 = req.address[15:8];
      end else begin
         byte0 = req.address[7:0];
         byte1 = ~req.address[7:0];
      end

      if (req.func == necirtx_pkg::FUNC_SEND) begin
         // A send request while a frame is running is dropped.
         if (state_ff.phase == PH_IDLE) begin
            s.frame_bits   = {~req.command, req.command, byte1, byte0};
            s.repeats_left = ({8'h00, req.repeat_count} > 16'(necirtx_pkg::MAX_REPEATS)) ?
                             8'(necirtx_pkg::MAX_REPEATS) : req.repeat_count;
            s.bit_index    = '0;
            s.phase        = PH_LEADER;
            s              = begin_mark(s, 1'b1, carrier_enable);
         end
      end else if (state_ff.phase != PH_IDLE) begin
         if (wc_dec != '0) begin
            s.wait_counter = wc_dec;
         end else if (state_ff.drive_level && state_ff.carrier_phase != '0) begin
            // Low part of one carrier pulse.
            s.drive_level  = 1'b0;
            s.wait_counter = necirtx_pkg::WAIT_W'(state_ff.carrier_phase);
         end else if (state_ff.drive_level || state_ff.burst_counter != '0) begin
            s.wait_counter  = wc_dec;
            s.burst_counter = bc_dec;
            if (bc_dec != '0) begin
               s.drive_level  = 1'b1;
               s.wait_counter = necirtx_pkg::PULSE_HIGH_US;
            end else begin
               // End of a mark.
               case (state_ff.phase)
                  PH_LEADER: s = begin_space(s, necirtx_pkg::LEADER_SPACE_US);
                  PH_BITS: begin
                     if (state_ff.frame_bits[state_ff.bit_index]) begin
                        s = begin_space(s, carrier_enable ? necirtx_pkg::ONE_SPACE_CAR_US :
                                                            necirtx_pkg::ONE_SPACE_US);
                     end else begin
                        s = begin_space(s, necirtx_pkg::ZERO_SPACE_US);
                     end
                  end
                  PH_REP_HEAD: s = begin_space(s, necirtx_pkg::REPEAT_SPACE_US);
                  PH_REP_TAIL: s = begin_space(s, necirtx_pkg::REPEAT_GAP_US);
                  default: begin
                     s.phase = PH_IDLE;
                     s       = begin_space(s, '0);
                     done    = 1'b1;
                  end
               endcase
            end
         end else begin
            // End of a space.
            s.wait_counter = wc_dec;
            case (state_ff.phase)
               PH_LEADER: begin
                  s.phase     = PH_BITS;
                  s.bit_index = '0;
                  s           = begin_mark(s, 1'b0, carrier_enable);
               end
               PH_BITS: begin
                  if (state_ff.bit_index == 5'd31) begin
                     s = after_data(s, carrier_enable);
                  end else begin
                     s.bit_index = state_ff.bit_index + 1'b1;
                     s           = begin_mark(s, 1'b0, carrier_enable);
                  end
               end
               PH_REP_HEAD: begin
                  s.phase = PH_REP_TAIL;
                  s       = begin_mark(s, 1'b0, carrier_enable);
               end
               PH_REP_TAIL: begin
                  if (state_ff.repeats_left != 8'd0) begin
                     s.repeats_left = state_ff.repeats_left - 1'b1;
                  end
                  s = after_data(s, carrier_enable);
               end
               default: begin
                  s.phase = PH_IDLE;
                  s       = begin_space(s, '0);
               end
            endcase
         end
      end

      state_in         = s;
      rsp_in.pin_level = s.drive_level;
      rsp_in.busy_res  = (s.phase != PH_IDLE);
      rsp_in.done_res  = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         rsp_ff   <= '0;
      end else if (step_en) begin
         state_ff <= state_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

   `NECIRTX_ASSERT_IMPLIES(a_idle_pin_low, clock, reset, state_ff.phase == PH_IDLE, !state_ff.drive_level, "pin driven high while idle")
   `NECIRTX_ASSERT_IMPLIES(a_busy_has_time, clock, reset, state_ff.phase != PH_IDLE, state_ff.wait_counter != '0, "running frame with an empty wait counter")
   `NECIRTX_ASSERT_IMPLIES(a_carrier_in_burst, clock, reset, state_ff.carrier_phase != '0, state_ff.burst_counter != '0, "carrier low time set outside a burst")

endmodule

// File: sim/nec_ir_frame_checker.sv
`timescale 1ns / 1ps
// Result checker for the NEC infrared transmitter: predicts every result from the requests
// it sees and compares it with what the block returns. Depends on necirtx_pkg only.

module nec_ir_frame_checker
   import necirtx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_func,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_command,
   input  logic [7:0]  req_repeat_count,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_pin_level,
   input  logic        rsp_busy_res,
   input  logic        rsp_done_res,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_data,
   output int          mismatches,
   output int          results_due,
   output logic        frame_busy
);

   typedef enum logic [2:0] {
      FRAME_IDLE,
      FRAME_LEADER,
      FRAME_BITS,
      FRAME_REP_HEAD,
      FRAME_REP_TAIL,
      FRAME_STOP
   } frame_phase_e;

   // Piece lengths in microseconds and carrier burst shapes, written out from the protocol.
   localparam logic [WAIT_W-1:0]  US_LONG_MARK         = WAIT_W'(9000);
   localparam logic [WAIT_W-1:0]  US_SHORT_MARK        = WAIT_W'(560);
   localparam logic [WAIT_W-1:0]  US_LEADER_SPACE      = WAIT_W'(4500);
   localparam logic [WAIT_W-1:0]  US_REPEAT_SPACE      = WAIT_W'(2250);
   localparam logic [WAIT_W-1:0]  US_ZERO_SPACE        = WAIT_W'(560);
   localparam logic [WAIT_W-1:0]  US_ONE_SPACE         = WAIT_W'(1690);
   localparam logic [WAIT_W-1:0]  US_ONE_SPACE_CARRIER = WAIT_W'(1680);
   localparam logic [WAIT_W-1:0]  US_REPEAT_GAP        = WAIT_W'(110000);
   localparam logic [WAIT_W-1:0]  US_PULSE_HIGH        = WAIT_W'(7);
   localparam logic [BURST_W-1:0] PULSES_LONG          = BURST_W'(375);
   localparam logic [BURST_W-1:0] PULSES_SHORT         = BURST_W'(23);
   localparam logic [CPH_W-1:0]   LOW_LONG             = CPH_W'(18);
   localparam logic [CPH_W-1:0]   LOW_SHORT            = CPH_W'(17);
   localparam logic [15:0]        PLAIN_ADDR_MAX       = 16'd255;

   frame_phase_e       phase;
   logic [4:0]         bit_idx;
   logic [31:0]        frame_word;
   logic [7:0]         repeats_left;
   logic [WAIT_W-1:0]  us_left;
   logic [BURST_W-1:0] pulses_left;
   logic [CPH_W-1:0]   low_len;
   logic               level;
   logic               carrier_on;
   rsp_type            pin_states_due[$];
   int                 results_seen;

   task report_fault(input string msg);
      mismatches++;
      if (mismatches <= 50) $display("%0t ns: %s", $time, msg);
   endtask

   task ir_begin_mark(input logic is_long);
      level = 1'b1;
      if (carrier_on) begin
         us_left     = US_PULSE_HIGH;
         pulses_left = is_long ? PULSES_LONG : PULSES_SHORT;
         low_len     = is_long ? LOW_LONG : LOW_SHORT;
      end else begin
         us_left     = is_long ? US_LONG_MARK : US_SHORT_MARK;
         pulses_left = BURST_W'(1);
         low_len     = '0;
      end
   endtask

   task ir_begin_space(input logic [WAIT_W-1:0] len);
      level       = 1'b0;
      us_left     = len;
      pulses_left = '0;
      low_len     = '0;
   endtask

   task ir_after_data();
      if (repeats_left != 0) begin
         phase = FRAME_REP_HEAD;
         ir_begin_mark(1'b1);
      end else begin
         phase = FRAME_STOP;
         ir_begin_mark(1'b0);
      end
   endtask

   task ir_mark_over(output logic done);
      done = 1'b0;
      case (phase)
         FRAME_LEADER: ir_begin_space(US_LEADER_SPACE);
         FRAME_BITS: begin
            if (frame_word[bit_idx])
               ir_begin_space(carrier_on ? US_ONE_SPACE_CARRIER : US_ONE_SPACE);
            else
               ir_begin_space(US_ZERO_SPACE);
         end
         FRAME_REP_HEAD: ir_begin_space(US_REPEAT_SPACE);
         FRAME_REP_TAIL: ir_begin_space(US_REPEAT_GAP);
         default: begin
            phase = FRAME_IDLE;
            ir_begin_space('0);
            done = 1'b1;
         end
      endcase
   endtask

   task ir_space_over();
      case (phase)
         FRAME_LEADER: begin
            phase   = FRAME_BITS;
            bit_idx = '0;
            ir_begin_mark(1'b0);
         end
         FRAME_BITS: begin
            if (bit_idx == 5'd31) begin
               ir_after_data();
            end else begin
               bit_idx = bit_idx + 1'b1;
               ir_begin_mark(1'b0);
            end
         end
         FRAME_REP_HEAD: begin
            phase = FRAME_REP_TAIL;
            ir_begin_mark(1'b0);
         end
         FRAME_REP_TAIL: begin
            if (repeats_left != 0) repeats_left = repeats_left - 1'b1;
            ir_after_data();
         end
         default: begin
            phase = FRAME_IDLE;
            ir_begin_space('0);
         end
      endcase
   endtask

   // One microsecond of the current mark or space.
   task ir_tick(output logic done);
      done = 1'b0;
      if (phase != FRAME_IDLE) begin
         if (us_left != 0) us_left = us_left - 1'b1;
         if (us_left == 0) begin
            if (level && low_len != 0) begin
               level   = 1'b0;
               us_left = WAIT_W'(low_len);
            end else if (level || pulses_left != 0) begin
               if (pulses_left != 0) pulses_left = pulses_left - 1'b1;
               if (pulses_left != 0) begin
                  level   = 1'b1;
                  us_left = US_PULSE_HIGH;
               end else begin
                  ir_mark_over(done);
               end
            end else begin
               ir_space_over();
            end
         end
      end
   endtask

   task ir_apply_request(input req_type item, output rsp_type want);
      logic [7:0] lo;
      logic [7:0] hi;
      logic       done;
      done = 1'b0;
      if (item.func == FUNC_SEND) begin
         // A send while a frame runs is dropped and does not count as a tick.
         if (phase == FRAME_IDLE) begin
            lo = item.address[7:0];
            hi = (item.address > PLAIN_ADDR_MAX) ? item.address[15:8] : ~item.address[7:0];
            frame_word   = {~item.command, item.command, hi, lo};
            repeats_left = (int'(item.repeat_count) > MAX_REPEATS) ? 8'(MAX_REPEATS)
                                                                   : item.repeat_count;
            bit_idx      = '0;
            phase        = FRAME_LEADER;
            ir_begin_mark(1'b1);
         end
      end else begin
         ir_tick(done);
      end
      want.pin_level = level;
      want.busy_res  = (phase != FRAME_IDLE);
      want.done_res  = done;
   endtask

   always @(posedge clock) begin : watch
      req_type item;
      rsp_type want;
      if (reset) begin
         phase        = FRAME_IDLE;
         bit_idx      = '0;
         frame_word   = '0;
         repeats_left = '0;
         us_left      = '0;
         pulses_left  = '0;
         low_len      = '0;
         level        = 1'b0;
         carrier_on   = 1'b1;
         results_seen = 0;
         mismatches   = 0;
         pin_states_due.delete();
      end else begin
         // The result register is one stage deep, so a result never belongs to the
         // request taken at the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (pin_states_due.size() == 0) begin
               report_fault($sformatf("result %0d arrived with nothing outstanding",
                                      results_seen));
            end else begin
               want = pin_states_due.pop_front();
               if (rsp_pin_level !== want.pin_level)
                  report_fault($sformatf("result %0d: pin_level %b, expected %b",
                                         results_seen, rsp_pin_level, want.pin_level));
               if (rsp_busy_res !== want.busy_res)
                  report_fault($sformatf("result %0d: busy_res %b, expected %b",
                                         results_seen, rsp_busy_res, want.busy_res));
               if (rsp_done_res !== want.done_res)
                  report_fault($sformatf("result %0d: done_res %b, expected %b",
                                         results_seen, rsp_done_res, want.done_res));
            end
            results_seen++;
         end
         if (req_valid && !req_stall) begin
            item.func         = req_func;
            item.address      = req_address;
            item.command      = req_command;
            item.repeat_count = req_repeat_count;
            ir_apply_request(item, want);
            pin_states_due.push_back(want);
         end
         if (csr_valid && csr_ready) carrier_on = csr_data;
      end
      results_due <= pin_states_due.size();
      frame_busy  <= (phase != FRAME_IDLE);
   end

endmodule

// File: sim/tb_nec_ir_transmitter_top.sv
`timescale 1ns / 1ps
// Top of the NEC infrared transmitter testbench: clock, reset, request and result traffic.
// Depends on necirtx_pkg, nec_ir_transmitter_top and nec_ir_frame_checker.

module tb_nec_ir_transmitter_top;
   import necirtx_pkg::*;

   // No correct run goes this many cycles without a single handshake: it is far longer than
   // the longest deliberate result hold-off and the longest request gap.
   localparam int QUIET_LIMIT = 3000;
   localparam int RANDOM_REQUESTS = 1320;

   // How a side paces itself over a stretch of requests.
   typedef enum int {
      PACE_NONE,
      PACE_LIGHT,
      PACE_FULL
   } pace_e;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic        req_func         = FUNC_TICK;
   logic [15:0] req_address      = '0;
   logic [7:0]  req_command      = '0;
   logic [7:0]  req_repeat_count = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic        rsp_pin_level;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic        csr_valid        = 1'b0;
   logic        csr_ready;
   logic        csr_data         = 1'b0;

   int          mismatches;
   int          results_due;
   logic        frame_busy;

   int          tx_left     = 0;
   int          rx_left     = 0;
   pace_e       tx_pace     = PACE_NONE;
   pace_e       rx_pace     = PACE_NONE;
   int          quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   nec_ir_transmitter_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_address      (req_address),
      .req_command      (req_command),
      .req_repeat_count (req_repeat_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pin_level    (rsp_pin_level),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   nec_ir_frame_checker i_frame_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_address      (req_address),
      .req_command      (req_command),
      .req_repeat_count (req_repeat_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pin_level    (rsp_pin_level),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .mismatches       (mismatches),
      .results_due      (results_due),
      .frame_busy       (frame_busy)
   );

   // Draws the number of idle cycles before the next request on one side. The pace is
   // chosen afresh for each stretch of 16 to 96 requests, so that runs with no idling at
   // all alternate with runs of light or heavy idling, and gaps land on every phase.
   function automatic int pick_wait(inout int left, inout pace_e pace);
      if (left == 0) begin
         left = $urandom_range(96, 16);
         case ($urandom_range(3, 0))
            0: pace = PACE_NONE;
            1: pace = PACE_LIGHT;
            default: pace = PACE_FULL;
         endcase
      end
      left--;
      case (pace)
         PACE_NONE: return 0;
         PACE_LIGHT: return $urandom_range(2, 0);
         default: return $urandom_range(18, 0);
      endcase
   endfunction

   function automatic req_type make_item(input logic func, input logic [15:0] address,
                                         input logic [7:0] command, input logic [7:0] count);
      req_type item;
      item.func         = func;
      item.address      = address;
      item.command      = command;
      item.repeat_count = count;
      return item;
   endfunction

   // Ticks carry a random payload as well: the block must ignore it.
   function automatic req_type random_item(input logic func);
      return make_item(func, 16'($urandom), 8'($urandom), 8'($urandom));
   endfunction

   // Offers one request, starting and ending at a falling edge. Valid stays high from one
   // request to the next when no gap is drawn; it is driven low only before a gap.
   task automatic drive_ir_request(input req_type item);
      int gap;
      gap = pick_wait(tx_left, tx_pace);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= item.func;
      req_address      <= item.address;
      req_command      <= item.command;
      req_repeat_count <= item.repeat_count;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Stops offering requests until every outstanding result has come back. Each request
   // yields exactly one result, so the block is then left quiet.
   task automatic settle_line();
      req_valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_carrier(input logic on);
      csr_valid <= 1'b1;
      csr_data  <= on;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Request side.
   initial begin
      int n;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Frame with the carrier on. Ticks while idle must leave the pin low whatever the
      // payload; the frame uses the highest address that is still sent with its
      // complement byte, and the sends that follow arrive while busy and are dropped.
      write_carrier(1'b1);
      drive_ir_request(make_item(FUNC_TICK, 16'h0000, 8'h00, 8'h00));
      drive_ir_request(make_item(FUNC_TICK, 16'hFFFF, 8'hFF, 8'hFF));
      drive_ir_request(make_item(FUNC_SEND, 16'h00FF, 8'h00, 8'h00));
      drive_ir_request(make_item(FUNC_SEND, 16'hFFFF, 8'hFF, 8'hFF));
      drive_ir_request(make_item(FUNC_SEND, 16'h0100, 8'h5A, 8'h01));
      drive_ir_request(make_item(FUNC_SEND, 16'h0000, 8'h00, 8'h00));
      for (n = 0; n < 10; n++) drive_ir_request(random_item(FUNC_TICK));

      // Carrier off while the frame is still in its leader: an extended address with one
      // repeat code is offered and dropped, since the block is busy.
      settle_line();
      write_carrier(1'b0);
      drive_ir_request(make_item(FUNC_SEND, 16'($urandom_range(65535, 256)), 8'($urandom),
                                 8'h01));
      drive_ir_request(make_item(FUNC_SEND, 16'h0000, 8'h00, 8'h00));
      for (n = 0; n < 10; n++) drive_ir_request(random_item(FUNC_TICK));

      // Random traffic with the carrier back on: mostly ticks, with a send request about
      // one time in sixteen. Halfway through the sender waits for every result to return.
      settle_line();
      write_carrier(1'b1);
      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == RANDOM_REQUESTS / 2) settle_line();
         drive_ir_request(random_item(($urandom_range(15, 0) == 0) ? FUNC_SEND : FUNC_TICK));
      end

      req_valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (mismatches == 0 && results_due == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Result side. Each result gets its own drawn stall. After the tenth result, and now
   // and then later on, the receiver holds off longer than any request gap while the sender
   // keeps offering, so the result register fills and the block has to stall its request side.
   initial begin
      int n;
      int taken;
      taken = 0;
      @(negedge clock);
      forever begin
         if (taken == 10 || $urandom_range(127, 0) == 0)
            n = $urandom_range(90, 40);
         else
            n = pick_wait(rx_left, rx_pace);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
         @(negedge clock);
      end
   end

   // Watchdog: ends the run if no handshake of any kind completes for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/necirtx_pkg.sv
rtl/core/necirtx_engine.sv
rtl/core/nec_ir_transmitter_top.sv
sim/nec_ir_frame_checker.sv
sim/tb_nec_ir_transmitter_top.sv
